>>> hdl/jsp_pkg.sv
`default_nettype none
package jsp_pkg;

   localparam int unsigned SAMPLE_W   = 12;
   localparam int unsigned DZ_W       = 11;
   localparam int unsigned PULSE_W    = 12;
   localparam int unsigned DEN_W      = 16;
   localparam int unsigned PROD_W     = 24;
   localparam int unsigned NUM_W      = 28;
   localparam int unsigned DIV_STEPS  = PULSE_W;
   localparam int unsigned PIPE_DEPTH = 3 + DIV_STEPS;
   localparam int unsigned CSR_IDX_W  = 2;
   localparam int unsigned CSR_DATA_W = 12;

   localparam logic [SAMPLE_W-1:0] MID_SCALE     = 12'd2048;
   localparam logic [SAMPLE_W-1:0] REF_THRESHOLD = 12'd100;
   localparam logic [DEN_W-1:0]    FULL_SCALE    = 16'd4095;
   localparam logic [DEN_W-1:0]    DEN_SCALE     = 16'd11;

   localparam logic [DZ_W-1:0]    DEAD_ZONE_RESET = 11'd150;
   localparam logic [PULSE_W-1:0] PULSE_MIN_RESET = 12'd500;
   localparam logic [PULSE_W-1:0] PULSE_MAX_RESET = 12'd2500;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_DEAD_ZONE = 2'd0,
      CSR_PULSE_MIN = 2'd1,
      CSR_PULSE_MAX = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic valid;
      logic comp;
   } pipe_tag_type;

endpackage
`default_nettype wire

>>> hdl/joystick_to_servo_pulse.sv
// Joystick to servo pulse converter.
// Request channel: req_valid/req_stall with the X, Y and reference samples.
// A request is taken at a clock edge with req_valid high and req_stall low.
// Response channel: rsp_valid/rsp_stall with the yaw and pitch compare
// values and the supply compensation flag, one response per request, in
// order. Two axis lanes run side by side, each a 15-register pipeline
// (dead zone, multiply, clamp, then one quotient bit per stage of a 12-step
// restoring divider); a merge stage adds the minimum pulse and holds the
// response. A new request is taken every cycle while the response side
// keeps up. When rsp_stall holds a waiting response, the whole pipeline
// holds and req_stall rises in the same cycle; nothing is dropped.
// Configuration: csr_valid/csr_ready, always ready; index 0 dead zone,
// 1 minimum pulse, 2 maximum pulse, other indexes ignored. Write only while
// no request is in flight.
// Reset (synchronous, active high) empties the pipeline and loads
// dead zone 150, minimum 500 and maximum 2500.
`default_nettype none
module joystick_to_servo_pulse (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic [jsp_pkg::SAMPLE_W-1:0]    req_stick_x,
   input  wire logic [jsp_pkg::SAMPLE_W-1:0]    req_stick_y,
   input  wire logic [jsp_pkg::SAMPLE_W-1:0]    req_reference_sample,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic      [jsp_pkg::PULSE_W-1:0]     rsp_yaw_pulse,
   output logic      [jsp_pkg::PULSE_W-1:0]     rsp_pitch_pulse,
   output logic                                 rsp_supply_compensated,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [jsp_pkg::CSR_IDX_W-1:0]   csr_index,
   input  wire logic [jsp_pkg::CSR_DATA_W-1:0]  csr_data
);
   import jsp_pkg::*;

   logic [DZ_W-1:0]    dead_zone_ff;
   logic [PULSE_W-1:0] pulse_min_ff;
   logic [PULSE_W-1:0] pulse_max_ff;
   logic [PULSE_W-1:0] span_range;

   logic               advance;
   logic               accept;
   pipe_tag_type       pipe_ff [PIPE_DEPTH];
   pipe_tag_type       tag_in;
   logic [DEN_W-1:0]   den_in;
   logic [DEN_W-1:0]   den1_ff;
   logic [DEN_W-1:0]   den2_ff;
   logic [NUM_W-1:0]   cap_in;
   logic [NUM_W-1:0]   cap2_ff;
   logic [PULSE_W-1:0] yaw_span;
   logic [PULSE_W-1:0] pitch_span;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         dead_zone_ff <= DEAD_ZONE_RESET;
         pulse_min_ff <= PULSE_MIN_RESET;
         pulse_max_ff <= PULSE_MAX_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_DEAD_ZONE: dead_zone_ff <= csr_data[DZ_W-1:0];
            CSR_PULSE_MIN: pulse_min_ff <= csr_data[PULSE_W-1:0];
            CSR_PULSE_MAX: pulse_max_ff <= csr_data[PULSE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   assign span_range = (pulse_max_ff >= pulse_min_ff) ? (pulse_max_ff - pulse_min_ff) : '0;

   assign accept       = req_valid && advance;
   assign req_stall    = !advance;
   assign tag_in.valid = accept;
   assign tag_in.comp  = req_reference_sample > REF_THRESHOLD;
   assign den_in       = DEN_W'(req_reference_sample) * DEN_SCALE;
   assign cap_in       = NUM_W'(den1_ff) * NUM_W'(span_range);

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_DEPTH; i++) begin
            pipe_ff[i] <= '0;
         end
      end else if (advance) begin
         pipe_ff[0] <= tag_in;
         for (int i = 1; i < PIPE_DEPTH; i++) begin
            pipe_ff[i] <= pipe_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         den1_ff <= den_in;
         den2_ff <= den1_ff;
         cap2_ff <= cap_in;
      end
   end

   jsp_lane u_yaw_lane (
      .clock      (clock),
      .advance    (advance),
      .raw        (req_stick_y),
      .dead_zone  (dead_zone_ff),
      .span_range (span_range),
      .comp       (pipe_ff[1].comp),
      .cap        (cap2_ff),
      .den        (den2_ff),
      .quotient   (yaw_span)
   );

   jsp_lane u_pitch_lane (
      .clock      (clock),
      .advance    (advance),
      .raw        (req_stick_x),
      .dead_zone  (dead_zone_ff),
      .span_range (span_range),
      .comp       (pipe_ff[1].comp),
      .cap        (cap2_ff),
      .den        (den2_ff),
      .quotient   (pitch_span)
   );

   jsp_merge u_merge (
      .clock                  (clock),
      .reset                  (reset),
      .tag                    (pipe_ff[PIPE_DEPTH-1]),
      .yaw_span               (yaw_span),
      .pitch_span             (pitch_span),
      .pulse_min              (pulse_min_ff),
      .rsp_stall              (rsp_stall),
      .advance                (advance),
      .rsp_valid              (rsp_valid),
      .rsp_yaw_pulse          (rsp_yaw_pulse),
      .rsp_pitch_pulse        (rsp_pitch_pulse),
      .rsp_supply_compensated (rsp_supply_compensated)
   );

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> pipe_ff[0].valid)
      else $error("taken request missing from pipeline entry");

   a_last_reaches_rsp: assert property (@(posedge clock) disable iff (reset)
      (pipe_ff[PIPE_DEPTH-1].valid && !req_stall) |=> rsp_valid)
      else $error("pipeline result lost before response register");

endmodule
`default_nettype wire

>>> hdl/jsp_lane.sv
`default_nettype none
module jsp_lane (
   input  wire logic                          clock,
   input  wire logic                          advance,
   input  wire logic [jsp_pkg::SAMPLE_W-1:0]  raw,
   input  wire logic [jsp_pkg::DZ_W-1:0]      dead_zone,
   input  wire logic [jsp_pkg::PULSE_W-1:0]   span_range,
   input  wire logic                          comp,
   input  wire logic [jsp_pkg::NUM_W-1:0]     cap,
   input  wire logic [jsp_pkg::DEN_W-1:0]     den,
   output logic      [jsp_pkg::PULSE_W-1:0]   quotient
);
   import jsp_pkg::*;

   logic [SAMPLE_W:0]   band_lo;
   logic [SAMPLE_W:0]   band_hi;
   logic [SAMPLE_W-1:0] sample_in;
   logic [SAMPLE_W-1:0] sample_ff;
   logic [PROD_W-1:0]   prod_in;
   logic [PROD_W-1:0]   prod_ff;
   logic [NUM_W-1:0]    prod4;
   logic [NUM_W-1:0]    num_in;
   logic [NUM_W-1:0]    num_ff;
   logic [DEN_W-1:0]    dvs_in;
   logic [DEN_W-1:0]    dvs_ff;

   logic [NUM_W-1:0]   rem_src [DIV_STEPS];
   logic [DEN_W-1:0]   dvs_src [DIV_STEPS];
   logic [PULSE_W-1:0] quo_src [DIV_STEPS];
   logic [NUM_W-1:0]   rem_in  [DIV_STEPS];
   logic [PULSE_W-1:0] quo_in  [DIV_STEPS];
   logic [NUM_W-1:0]   rem_ff  [DIV_STEPS];
   logic [DEN_W-1:0]   dvs_step_ff [DIV_STEPS];
   logic [PULSE_W-1:0] quo_ff  [DIV_STEPS];

   assign band_lo = {1'b0, MID_SCALE} - {2'b00, dead_zone};
   assign band_hi = {1'b0, MID_SCALE} + {2'b00, dead_zone};

   always_comb begin
      if (({1'b0, raw} > band_lo) && ({1'b0, raw} < band_hi)) begin
         sample_in = MID_SCALE;
      end else begin
         sample_in = raw;
      end
   end

   assign prod_in = PROD_W'(sample_ff) * PROD_W'(span_range);
   assign prod4   = NUM_W'({prod_ff, 2'b00});

   always_comb begin
      if (comp) begin
         num_in = (prod4 > cap) ? cap : prod4;
         dvs_in = den;
      end else begin
         num_in = NUM_W'(prod_ff);
         dvs_in = FULL_SCALE;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sample_ff <= sample_in;
         prod_ff   <= prod_in;
         num_ff    <= num_in;
         dvs_ff    <= dvs_in;
      end
   end

   for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
      localparam int unsigned BIT = DIV_STEPS - 1 - j;
      logic [NUM_W-1:0] trial;
      logic             take;

      if (j == 0) begin : g_first
         assign rem_src[j] = num_ff;
         assign dvs_src[j] = dvs_ff;
         assign quo_src[j] = '0;
      end else begin : g_next
         assign rem_src[j] = rem_ff[j-1];
         assign dvs_src[j] = dvs_step_ff[j-1];
         assign quo_src[j] = quo_ff[j-1];
      end

      assign trial     = NUM_W'(dvs_src[j]) << BIT;
      assign take      = rem_src[j] >= trial;
      assign rem_in[j] = take ? (rem_src[j] - trial) : rem_src[j];
      assign quo_in[j] = {quo_src[j][PULSE_W-2:0], take};

      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[j]      <= rem_in[j];
            dvs_step_ff[j] <= dvs_src[j];
            quo_ff[j]      <= quo_in[j];
         end
      end
   end

   assign quotient = quo_ff[DIV_STEPS-1];

endmodule
`default_nettype wire

>>> hdl/jsp_merge.sv
`default_nettype none
module jsp_merge (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire jsp_pkg::pipe_tag_type         tag,
   input  wire logic [jsp_pkg::PULSE_W-1:0]   yaw_span,
   input  wire logic [jsp_pkg::PULSE_W-1:0]   pitch_span,
   input  wire logic [jsp_pkg::PULSE_W-1:0]   pulse_min,
   input  wire logic                          rsp_stall,
   output logic                               advance,
   output logic                               rsp_valid,
   output logic      [jsp_pkg::PULSE_W-1:0]   rsp_yaw_pulse,
   output logic      [jsp_pkg::PULSE_W-1:0]   rsp_pitch_pulse,
   output logic                               rsp_supply_compensated
);
   import jsp_pkg::*;

   logic               valid_ff;
   logic               valid_in;
   logic [PULSE_W-1:0] yaw_ff;
   logic [PULSE_W-1:0] pitch_ff;
   logic               comp_ff;

   assign advance  = !valid_ff || !rsp_stall;
   assign valid_in = advance ? tag.valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         yaw_ff   <= pulse_min + yaw_span;
         pitch_ff <= pulse_min + pitch_span;
         comp_ff  <= tag.comp;
      end
   end

   assign rsp_valid              = valid_ff;
   assign rsp_yaw_pulse          = yaw_ff;
   assign rsp_pitch_pulse        = pitch_ff;
   assign rsp_supply_compensated = comp_ff;

endmodule
`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 100ps
module tb_top;
   import jsp_pkg::*;

   localparam int unsigned WATCHDOG_LIMIT = 5000;
   localparam int unsigned DRAIN_CYCLES   = PIPE_DEPTH + 4;
   localparam int unsigned BLOCK_ITEMS    = 120;
   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;

   typedef struct {
      logic [PULSE_W-1:0] yaw;
      logic [PULSE_W-1:0] pitch;
      logic               comp;
   } servo_pulses_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_valid            = 1'b0;
   logic                  req_stall;
   logic [SAMPLE_W-1:0]   req_stick_x          = '0;
   logic [SAMPLE_W-1:0]   req_stick_y          = '0;
   logic [SAMPLE_W-1:0]   req_reference_sample = '0;
   logic                  rsp_valid;
   logic                  rsp_stall            = 1'b0;
   logic [PULSE_W-1:0]    rsp_yaw_pulse;
   logic [PULSE_W-1:0]    rsp_pitch_pulse;
   logic                  rsp_supply_compensated;
   logic                  csr_valid            = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index            = '0;
   logic [CSR_DATA_W-1:0] csr_data             = '0;

   logic [DZ_W-1:0]    dead_zone_cfg = DEAD_ZONE_RESET;
   logic [PULSE_W-1:0] pulse_min_cfg = PULSE_MIN_RESET;
   logic [PULSE_W-1:0] pulse_max_cfg = PULSE_MAX_RESET;

   servo_pulses_type pending_pulses[$];

   int unsigned send_idle_pct  = 0;
   int unsigned rsp_stall_pct  = 0;
   int unsigned hold_off_left  = 0;
   int unsigned idle_cycles    = 0;
   int unsigned error_count    = 0;
   int unsigned request_count  = 0;
   int unsigned response_count = 0;
   int unsigned comp_count     = 0;
   int unsigned write_count    = 0;

   joystick_to_servo_pulse u_top (
      .clock                  (clock),
      .reset                  (reset),
      .req_valid              (req_valid),
      .req_stall              (req_stall),
      .req_stick_x            (req_stick_x),
      .req_stick_y            (req_stick_y),
      .req_reference_sample   (req_reference_sample),
      .rsp_valid              (rsp_valid),
      .rsp_stall              (rsp_stall),
      .rsp_yaw_pulse          (rsp_yaw_pulse),
      .rsp_pitch_pulse        (rsp_pitch_pulse),
      .rsp_supply_compensated (rsp_supply_compensated),
      .csr_valid              (csr_valid),
      .csr_ready              (csr_ready),
      .csr_index              (csr_index),
      .csr_data               (csr_data)
   );

   always #5 clock = ~clock;

   function automatic logic [PULSE_W-1:0] axis_pulse_width(input logic [SAMPLE_W-1:0] raw,
                                                           input logic [SAMPLE_W-1:0] vref,
                                                           input logic comp);
      longint a;
      longint d;
      longint den;
      longint num;
      longint cap;
      longint span;
      a = raw;
      if (int'(raw) > int'(MID_SCALE) - int'(dead_zone_cfg) &&
          int'(raw) < int'(MID_SCALE) + int'(dead_zone_cfg)) begin
         a = MID_SCALE;
      end
      d = (pulse_max_cfg >= pulse_min_cfg) ? longint'(pulse_max_cfg) - pulse_min_cfg : 0;
      if (comp) begin
         den = longint'(DEN_SCALE) * vref;
         num = 4 * a * d;
         cap = den * d;
         if (num > cap) begin
            num = cap;
         end
         span = num / den;
      end else begin
         span = (a * d) / longint'(FULL_SCALE);
      end
      return PULSE_W'(longint'(pulse_min_cfg) + span);
   endfunction

   function automatic servo_pulses_type compute_servo_pulses(input logic [SAMPLE_W-1:0] x,
                                                             input logic [SAMPLE_W-1:0] y,
                                                             input logic [SAMPLE_W-1:0] vref);
      servo_pulses_type p;
      p.comp  = vref > REF_THRESHOLD;
      p.yaw   = axis_pulse_width(y, vref, p.comp);
      p.pitch = axis_pulse_width(x, vref, p.comp);
      return p;
   endfunction

   function automatic logic [SAMPLE_W-1:0] random_stick();
      int band_edge;
      case ($urandom_range(3))
         0: begin
            band_edge = int'(MID_SCALE) + ($urandom_range(1) ? int'(dead_zone_cfg)
                                                              : -int'(dead_zone_cfg));
            band_edge = band_edge + int'($urandom_range(4)) - 2;
            if (band_edge < 0) band_edge = 0;
            if (band_edge > 4095) band_edge = 4095;
            return SAMPLE_W'(band_edge);
         end
         1: return $urandom_range(1) ? SAMPLE_W'($urandom_range(3))
                                     : SAMPLE_W'(4092 + $urandom_range(3));
         default: return SAMPLE_W'($urandom_range(4095));
      endcase
   endfunction

   function automatic logic [SAMPLE_W-1:0] random_reference();
      case ($urandom_range(3))
         0: return SAMPLE_W'($urandom_range(100));
         1: return SAMPLE_W'($urandom_range(110, 95));
         2: return SAMPLE_W'($urandom_range(400, 101));
         default: return SAMPLE_W'($urandom_range(4095));
      endcase
   endfunction

   task automatic report_mismatch(input string field, input int unsigned want,
                                  input int unsigned got);
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, field, want, got);
      error_count++;
   endtask

   always @(negedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_off_left > 0) begin
         rsp_stall <= 1'b1;
         hold_off_left--;
      end else begin
         rsp_stall <= $urandom_range(99) < rsp_stall_pct;
      end
   end

   always @(posedge clock) begin
      servo_pulses_type want;
      if (!reset) begin
         if (csr_valid && csr_ready) begin
            write_count++;
            case (csr_index)
               CSR_DEAD_ZONE: dead_zone_cfg = csr_data[DZ_W-1:0];
               CSR_PULSE_MIN: pulse_min_cfg = csr_data;
               CSR_PULSE_MAX: pulse_max_cfg = csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            request_count++;
            pending_pulses.push_back(compute_servo_pulses(req_stick_x, req_stick_y,
                                                          req_reference_sample));
         end
         if (rsp_valid && !rsp_stall) begin
            response_count++;
            if (rsp_supply_compensated) comp_count++;
            if (pending_pulses.size() == 0) begin
               $display("%0t: response with none expected, actual yaw %0d pitch %0d comp %0d",
                        $time, rsp_yaw_pulse, rsp_pitch_pulse, rsp_supply_compensated);
               error_count++;
            end else begin
               want = pending_pulses.pop_front();
               if (rsp_yaw_pulse !== want.yaw)
                  report_mismatch("yaw_pulse", want.yaw, rsp_yaw_pulse);
               if (rsp_pitch_pulse !== want.pitch)
                  report_mismatch("pitch_pulse", want.pitch, rsp_pitch_pulse);
               if (rsp_supply_compensated !== want.comp)
                  report_mismatch("supply_compensated", want.comp, rsp_supply_compensated);
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
         $display("tb_top: errors");
         $finish;
      end
   end

   task automatic send_samples(input logic [SAMPLE_W-1:0] x, input logic [SAMPLE_W-1:0] y,
                               input logic [SAMPLE_W-1:0] vref);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid            <= 1'b1;
      req_stick_x          <= x;
      req_stick_y          <= y;
      req_reference_sample <= vref;
      do @(posedge clock); while (req_stall);
   endtask

   task automatic drain_pipeline();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_pulses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] reg_index,
                                 input logic [CSR_DATA_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= reg_index;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic load_limits(input logic [DZ_W-1:0] dz, input logic [PULSE_W-1:0] lo,
                              input logic [PULSE_W-1:0] hi);
      write_register(CSR_DEAD_ZONE, {$urandom_range(1) == 1, dz});
      write_register(CSR_PULSE_MIN, lo);
      write_register(CSR_PULSE_MAX, hi);
   endtask

   task automatic load_random_limits();
      logic [DZ_W-1:0]    dz;
      logic [PULSE_W-1:0] lo;
      logic [PULSE_W-1:0] hi;
      case ($urandom_range(5))
         0: dz = '0;
         1: dz = '1;
         2, 3: dz = DZ_W'($urandom_range(400));
         default: dz = DZ_W'($urandom_range(2047));
      endcase
      case ($urandom_range(5))
         0: begin
            lo = '0;
            hi = '1;
         end
         1: begin
            lo = PULSE_W'($urandom_range(4095));
            hi = PULSE_W'($urandom_range(lo));
         end
         2: begin
            lo = PULSE_W'($urandom_range(4095));
            hi = lo;
         end
         default: begin
            lo = PULSE_W'($urandom_range(1500));
            hi = PULSE_W'($urandom_range(4095, lo));
         end
      endcase
      if ($urandom_range(3) == 0)
         write_register(CSR_UNUSED, CSR_DATA_W'($urandom_range(4095)));
      load_limits(dz, lo, hi);
   endtask

   task automatic test_reset_defaults();
      send_samples(12'd0, 12'd0, 12'd0);
      send_samples(12'd4095, 12'd4095, 12'd4095);
      send_samples(12'd2048, 12'd2048, 12'd2048);
      send_samples(12'd1898, 12'd2198, 12'd100);
      send_samples(12'd1899, 12'd2197, 12'd101);
      send_samples(12'd4095, 12'd0, 12'd101);
      send_samples(12'd3000, 12'd1000, 12'd1490);
      send_samples(12'd2730, 12'd4095, 12'd4095);
      drain_pipeline();
   endtask

   task automatic test_register_extremes();
      load_limits('0, 12'd0, 12'd4095);
      send_samples(12'd2047, 12'd2049, 12'd0);
      send_samples(12'd2048, 12'd4095, 12'd102);
      drain_pipeline();
      load_limits('1, 12'd100, 12'd3000);
      send_samples(12'd1, 12'd2, 12'd50);
      send_samples(12'd4094, 12'd4095, 12'd2000);
      send_samples(12'd0, 12'd2048, 12'd101);
      drain_pipeline();
      load_limits(11'd40, 12'd4095, 12'd0);
      send_samples(12'd4095, 12'd0, 12'd200);
      send_samples(12'd1000, 12'd3000, 12'd90);
      drain_pipeline();
      load_limits(11'd300, 12'd4095, 12'd4095);
      send_samples(12'd4095, 12'd100, 12'd4095);
      drain_pipeline();
      write_register(CSR_UNUSED, 12'hfff);
      load_limits(DEAD_ZONE_RESET, PULSE_MIN_RESET, PULSE_MAX_RESET);
      send_samples(12'd1500, 12'd3500, 12'd1490);
      drain_pipeline();
   endtask

   task automatic test_random_traffic(input int unsigned sender_pct,
                                      input int unsigned receiver_pct,
                                      input int unsigned n_items);
      send_idle_pct = sender_pct;
      rsp_stall_pct = receiver_pct;
      for (int unsigned i = 0; i < n_items; i++) begin
         if (i % BLOCK_ITEMS == 0) begin
            drain_pipeline();
            load_random_limits();
         end
         send_samples(random_stick(), random_stick(), random_reference());
      end
      drain_pipeline();
   endtask

   task automatic test_backpressure();
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      load_random_limits();
      @(posedge clock);
      hold_off_left = 250;
      repeat (40) send_samples(random_stick(), random_stick(), random_reference());
      drain_pipeline();
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_reset_defaults();
      test_register_extremes();
      test_random_traffic(11, 77, 470);
      test_random_traffic(77, 11, 470);
      test_random_traffic(0, 0, 470);
      test_backpressure();
      $display("tb_top: %0d requests, %0d responses (%0d supply-compensated), %0d writes",
               request_count, response_count, comp_count, write_count);
      $display("tb_top: dead zone and pulse limits swept to extremes under three flow mixes");
      if (error_count == 0) begin
         $display("tb_top: clean");
      end else begin
         $display("tb_top: errors");
      end
      $finish;
   end

endmodule
